// ===== src/gcd_pkg.sv =====
`default_nettype none

package gcd_pkg;

  localparam int unsigned OperandW = 32;
  localparam int unsigned StepW    = 6;
  localparam logic [StepW-1:0] StepMax = 6'd63;

  typedef struct packed {
    logic [OperandW-1:0] first_operand;
    logic [OperandW-1:0] second_operand;
  } gcd_in_t;

  typedef struct packed {
    logic [OperandW-1:0] divisor;
    logic [StepW-1:0]    step_count;
  } gcd_out_t;

  // one-hot sequencer codes
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_HOLD  = 4'b1000
  } gcd_state_e;

endpackage

`default_nettype wire

// ===== src/gcd_stream_if.sv =====
`default_nettype none

interface gcd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/gcd_euclid_remainder_unit.sv =====
`default_nettype none

// Channel  Dir  Payload                                    Moves a word when
// in_i     in   gcd_in_t  {first_operand, second_operand}  valid && ready
// out_o    out  gcd_out_t {divisor, step_count}            valid && ready
//
// Steps: the idle state takes the word, then per remainder step a check state
//   plus the shared restoring divider (one quotient bit a cycle), then a last
//   check state and an S_HOLD state that posts the result.
// The divider is the only arithmetic unit; every remainder step reuses it.
// Reset clears the sequencer and the output valid only; no clearing pass.
// in_i.ready is high only while the unit is idle. A finished result sits in
//   the output register, so the next word is taken while it waits.
// If the output register is still full when a new result is ready, the
//   sequencer parks in S_HOLD until out_o.ready frees it.

module gcd_euclid_remainder_unit
  import gcd_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  gcd_stream_if.sink            in_i,
  gcd_stream_if.source          out_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  gcd_state_e          state_q, state_d;
  logic [WIDTH-1:0]    high_q, high_d;   // dividend, shifted out MSB first
  logic [WIDTH-1:0]    low_q, low_d;     // divisor of the current step
  logic [WIDTH-1:0]    rem_q, rem_d;     // partial remainder
  logic [CntW-1:0]     cnt_q, cnt_d;     // divider bits left, minus one
  logic [StepW-1:0]    steps_q, steps_d;
  logic                out_valid_q, out_valid_d;
  gcd_out_t            out_q, out_d;

  // shared divider datapath
  logic [WIDTH:0]      trial;
  logic                fits;
  logic [WIDTH:0]      trial_sub;
  logic [WIDTH-1:0]    rem_next;

  logic                in_fire;
  logic                out_free;
  logic                a_gt_b;
  logic [WIDTH-1:0]    opnd_a, opnd_b;

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign out_free      = !out_valid_q || out_o.ready;

  // operands taken modulo 2^WIDTH
  assign opnd_a = WIDTH'(in_i.payload.first_operand);
  assign opnd_b = WIDTH'(in_i.payload.second_operand);
  assign a_gt_b = opnd_a > opnd_b;

  assign trial     = {rem_q, high_q[WIDTH-1]};
  assign fits      = trial >= {1'b0, low_q};
  assign trial_sub = trial - {1'b0, low_q};
  assign rem_next  = fits ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];

  always_comb begin
    state_d     = state_q;
    high_d      = high_q;
    low_d       = low_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          high_d  = a_gt_b ? opnd_a : opnd_b;
          low_d   = a_gt_b ? opnd_b : opnd_a;
          steps_d = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (low_q == '0) begin
          state_d = S_HOLD;
        end else begin
          rem_d   = '0;
          cnt_d   = CntW'(WIDTH - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = rem_next;
        high_d = {high_q[WIDTH-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          // high <- low, low <- high mod low
          high_d  = low_q;
          low_d   = rem_next;
          steps_d = (steps_q == StepMax) ? steps_q : steps_q + 1'b1;
          state_d = S_CHECK;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_d.divisor    = OperandW'(high_q);
          out_d.step_count = steps_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    high_q  <= high_d;
    low_q   <= low_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    steps_q <= steps_d;
    out_q   <= out_d;
  end

  // partial remainder always below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < low_q))
    else $error("partial remainder not below divisor");

  // operands stay ordered between steps
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (high_q >= low_q))
    else $error("high below low at step check");

  // each finished step bumps the count or holds it at saturation
  a_step_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '0) |=>
      (steps_q == StepMax || steps_q == $past(steps_q) + 1'b1))
    else $error("step count did not advance");

  // a result is posted only once low has reached zero
  a_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) |-> (low_q == '0))
    else $error("result posted with nonzero low");

  // a posted result shows up as valid next cycle
  a_post_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD && out_free) |=> (out_o.valid && state_q == S_IDLE))
    else $error("result not presented");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Stream test of gcd_euclid_remainder_unit.
// Operand words go in through in_if and every accepted word is run through a
// local Euclid predictor. The predicted {divisor, step_count} is queued at the
// edge where the block takes the word. Each word the block hands out on out_if
// is checked against the head of that queue.
// Inputs change on the falling edge. Handshakes are sampled on the rising edge.

module tb;
  import gcd_pkg::*;

  localparam int unsigned ClkPeriod = 12;
  // The worst case grows with the step count. About 46 steps fit in 32 bits.
  localparam int unsigned TailCycles = 1600;

  logic clk;
  logic rst_n;

  gcd_stream_if #(.payload_t(gcd_in_t))  in_if ();
  gcd_stream_if #(.payload_t(gcd_out_t)) out_if ();

  gcd_euclid_remainder_unit #(
    .WIDTH(OperandW)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  gcd_out_t gcd_expected_q[$];  // predicted results, oldest first
  int unsigned mismatch_count;
  int unsigned send_idle_pct;   // chance in 100 that the sender skips a cycle
  int unsigned recv_stall_pct;  // chance in 100 that ready stays low
  int unsigned hold_off_cycles; // forced low-ready stretch, counted down below

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  // Euclid by remainder. The step count saturates at StepMax.
  function automatic gcd_out_t gcd_predict(logic [OperandW-1:0] a, logic [OperandW-1:0] b);
    logic [OperandW-1:0] hi;
    logic [OperandW-1:0] lo;
    logic [OperandW-1:0] rem;
    logic [StepW-1:0]    steps;
    gcd_out_t            res;
    hi    = (a > b) ? a : b;
    lo    = (a > b) ? b : a;
    steps = '0;
    while (lo != '0) begin
      rem = hi % lo;
      hi  = lo;
      lo  = rem;
      if (steps < StepMax) steps = steps + 1'b1;
    end
    res.divisor    = hi;
    res.step_count = steps;
    return res;
  endfunction

  // Operand mix. Small values dominate so the serial divider does not eat the
  // budget. Full-range values, pairs with a shared factor and zeros are mixed in.
  function automatic logic [OperandW-1:0] pick_operand(int unsigned g);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom_range(255);
    else if (sel < 70) return $urandom_range(65535);
    else if (sel < 85) return $urandom();
    else if (sel < 95) return g * $urandom_range(65535);
    else return '0;
  endfunction

  // Ready driver. A pending hold-off wins over the random stalls.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles != 0) begin
        out_if.ready <= 1'b0;
        hold_off_cycles = hold_off_cycles - 1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker. Every output word must match the oldest prediction.
  initial begin
    gcd_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (gcd_expected_q.size() == 0) begin
          $error("unexpected result word: divisor %0d step_count %0d",
                 out_if.payload.divisor, out_if.payload.step_count);
          mismatch_count++;
        end else begin
          want = gcd_expected_q.pop_front();
          if (out_if.payload.divisor !== want.divisor) begin
            $error("divisor: expected %0d, actual %0d", want.divisor, out_if.payload.divisor);
            mismatch_count++;
          end
          if (out_if.payload.step_count !== want.step_count) begin
            $error("step_count: expected %0d, actual %0d",
                   want.step_count, out_if.payload.step_count);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Offer one operand word. This is entered and left at a falling edge. Valid is
  // left high, so back-to-back words never drop it within one step.
  task automatic send_operands(logic [OperandW-1:0] a, logic [OperandW-1:0] b);
    gcd_in_t word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    word.first_operand  = a;
    word.second_operand = b;
    in_if.valid   <= 1'b1;
    in_if.payload <= word;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    gcd_expected_q.push_back(gcd_predict(a, b));
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (gcd_expected_q.size() != 0);
  endtask

  // Edge operands: zeros, all ones, equal pairs, powers of two, large primes,
  // and consecutive Fibonacci numbers for the longest remainder chain.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_operands(32'd0, 32'd0);
    send_operands(32'd0, 32'd12345);
    send_operands(32'hFFFF_FFFF, 32'd0);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'd1);
    send_operands(32'd1, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    send_operands(32'h8000_0000, 32'h4000_0000);
    send_operands(32'h8000_0000, 32'd0);
    send_operands(32'd12, 32'd18);
    send_operands(32'd18, 32'd12);
    send_operands(32'd4294967291, 32'd4294967279);
    send_operands(32'd2971215073, 32'd1836311903);
    send_operands(32'd1836311903, 32'd2971215073);
    send_operands(32'd7, 32'd7);
    send_operands(32'd1, 32'd0);
    wait_results_drained();
  endtask

  // Random operand words under one idling profile.
  task automatic test_random(int unsigned count, int unsigned idle_pct, int unsigned stall_pct);
    int unsigned g;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      g = $urandom_range(1, 65535);
      send_operands(pick_operand(g), pick_operand(g));
    end
    wait_results_drained();
  endtask

  // Receiver goes quiet for a long stretch while words keep coming. The output
  // register fills, the sequencer parks and the input stalls.
  task automatic test_backpressure();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 2000;
    repeat (6) send_operands($urandom_range(1000), $urandom_range(1000));
    wait_results_drained();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.payload    = '0;
    mismatch_count   = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_cycles  = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random(212, 0, 0);
    test_random(212, 84, 0);
    test_backpressure();
    test_random(212, 0, 84);
    test_random(212, 22, 22);

    wait_results_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
